// ----- rtl/psk_pkg.sv -----
// ----------------------------------------------------------------------------
// psk_pkg: shared types and constants of the polyline mitre stroker
// Item structs, FSM states and the control/status of the shared div/sqrt unit.
// ----------------------------------------------------------------------------
`default_nettype none
package psk_pkg;

  localparam int COORD_WIDTH_DEF = 24;
  localparam int MAX_POINTS_DEF  = 4096;
  localparam int UNIT_ONE        = 16384;
  localparam int L_CAP           = 16777216;
  localparam int REVERSE_LIMIT   = 64;

  typedef struct packed {
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic               final_point;
  } point_t;

  typedef struct packed {
    logic signed [23:0] vert_x;
    logic signed [23:0] vert_y;
    logic               side;
    logic [11:0]        point_index;
    logic               single_point_error;
    logic               end_of_line;
  } vert_t;

  typedef struct packed {
    logic start;
    logic sqrt_mode;
  } dv_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } dv_stat_t;

  typedef enum logic [4:0] {
    S_IDLE, S_ERR, S_DIFF, S_NSHIFT, S_NSQX, S_NSQY, S_NSQS, S_NSQRT,
    S_NDIVX, S_NWX, S_NDIVY, S_NWY, S_DIR, S_PSUM, S_MIT, S_DOT1, S_DOT2,
    S_DOT3, S_LDIV, S_OFFX, S_OFFY, S_OFFR, S_EMP, S_EMM
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/psk_stream_if.sv -----
// ----------------------------------------------------------------------------
// psk stream interfaces
// Valid/ready channels for input points and result vertices.
// ----------------------------------------------------------------------------
`default_nettype none
interface psk_point_if;
  import psk_pkg::*;
  logic   valid;
  logic   ready;
  point_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface psk_vert_if;
  import psk_pkg::*;
  logic  valid;
  logic  ready;
  vert_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/polyline_mitre_stroker.sv -----
// ----------------------------------------------------------------------------
// polyline_mitre_stroker: streaming mitre-join stroker
// Turns polyline points into pairs of offset vertices joined by mitres, or an error item for a single point.
// ----------------------------------------------------------------------------
// Throughput: one point at a time; the bit-serial div/sqrt unit sets it, with up to
//   two normalizations (one sqrt and two divides each) and one width divide per pair;
//   a final point makes two pairs.
// Output register lets the next point enter while the last vertex waits.
// Reset (rst, synchronous): no point held, counter 0, half_width = 256.
`default_nettype none
module polyline_mitre_stroker #(
  parameter int MAX_POINTS  = psk_pkg::MAX_POINTS_DEF,
  parameter int COORD_WIDTH = psk_pkg::COORD_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  psk_point_if.sink        points,
  psk_vert_if.source       verts
);
  import psk_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int CNT_W = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
  localparam int MW    = (CW + 1 > 26) ? CW + 1 : 26;   // magnitude width
  localparam logic signed [39:0] SAT_HI = (40'sd1 <<< (CW - 1)) - 40'sd1;
  localparam logic signed [39:0] SAT_LO = -SAT_HI - 40'sd1;
  localparam logic [CNT_W-1:0]   CNT_LAST = CNT_W'(MAX_POINTS - 1);

  state_t state, state_next;

  // polyline state
  logic signed [CW-1:0] prev_x, prev_y;
  logic signed [15:0]   prev_dir_x, prev_dir_y;
  logic [1:0]           points_seen;
  logic [CNT_W-1:0]     point_counter;
  logic [15:0]          half_width;

  // captured item
  logic signed [CW-1:0] in_x, in_y;
  logic                 fin;

  // normalizer working set
  logic [MW-1:0]        ax, ay;
  logic                 nsx, nsy, nrm_ok, nrm_mitre;
  logic [25:0]          len;
  logic signed [15:0]   nux, nuy;

  // pair job
  logic signed [15:0]   u0x, u0y, u1x, u1y, mx, my;
  logic signed [CW-1:0] ppx, ppy;
  logic [CNT_W-1:0]     pidx;
  logic                 peol;
  logic [24:0]          l_reg;
  logic signed [53:0]   acc, prod;
  logic signed [26:0]   ox, oy;

  // output register
  logic  ov;
  vert_t od;

  // shared multiplier and div/sqrt unit
  logic signed [26:0] mul_a, mul_b;
  dv_ctrl_t           dv_ctrl;
  dv_stat_t           dv_stat;
  logic [51:0]        opa;
  logic [29:0]        opb;
  logic [47:0]        dv_q;

  psk_divsqrt u_dv (
    .clk  (clk),
    .rst  (rst),
    .ctrl (dv_ctrl),
    .opa  (opa),
    .opb  (opb),
    .stat (dv_stat),
    .q    (dv_q)
  );

  // ---------------- combinational helpers ----------------
  logic [31:0]          wx, wy;
  logic signed [CW-1:0] pt_x, pt_y;
  logic signed [CW:0]   dfx, dfy;
  logic signed [16:0]   sx, sy;
  logic [17:0]          s_abs;
  logic signed [MW:0]   nv_x, nv_y;
  logic [MW-1:0]        m_max;
  logic [14:0]          qclamp;
  logic signed [15:0]   nq;
  logic signed [53:0]   dot;
  logic signed [15:0]   dsel_x, dsel_y;
  logic signed [39:0]   sum_x, sum_y;
  logic                 out_free;
  logic                 ov_load;
  logic [31:0]          idx_ext;
  logic [CNT_W-1:0]     cnt_inc;

  // coordinates are taken from the low CW bits, zero-filled above 24
  assign wx   = {8'b0, points.data.point_x};
  assign wy   = {8'b0, points.data.point_y};
  assign pt_x = signed'(wx[CW-1:0]);
  assign pt_y = signed'(wy[CW-1:0]);

  assign dfx   = (CW + 1)'(in_x) - (CW + 1)'(prev_x);
  assign dfy   = (CW + 1)'(in_y) - (CW + 1)'(prev_y);
  assign sx    = 17'(u0x) + 17'(u1x);
  assign sy    = 17'(u0y) + 17'(u1y);
  assign s_abs = 18'(sx[16] ? -sx : sx) + 18'(sy[16] ? -sy : sy);
  assign nv_x  = (state == S_DIFF) ? (MW + 1)'(dfx) : (MW + 1)'(sx);
  assign nv_y  = (state == S_DIFF) ? (MW + 1)'(dfy) : (MW + 1)'(sy);
  assign m_max = (ax > ay) ? ax : ay;

  assign qclamp = (dv_q > 48'(UNIT_ONE)) ? 15'(UNIT_ONE) : dv_q[14:0];
  assign dot    = acc + prod;
  assign out_free = !ov || verts.ready;
  // a new item enters the output register in the error and emit states
  assign ov_load  = out_free && (state inside {S_ERR, S_EMP, S_EMM});
  assign cnt_inc  = (point_counter == CNT_LAST) ? '0 : point_counter + 1'b1;
  assign idx_ext  = 32'(pidx);

  always_comb begin
    if (state == S_NWX) nq = nsx ? -signed'(16'(qclamp)) : signed'(16'(qclamp));
    else                nq = nsy ? -signed'(16'(qclamp)) : signed'(16'(qclamp));
  end

  // direction of the new segment, with fallbacks for a zero-length one
  always_comb begin
    if (nrm_ok) begin
      dsel_x = nux;
      dsel_y = nuy;
    end else if (points_seen == 2'd2) begin
      dsel_x = prev_dir_x;
      dsel_y = prev_dir_y;
    end else begin
      dsel_x = 16'(UNIT_ONE);
      dsel_y = '0;
    end
  end

  function automatic logic signed [26:0] rnd14(input logic signed [53:0] p);
    logic [53:0] a;
    logic [53:0] r;
    a = p[53] ? 54'(-p) : 54'(p);
    r = (a + 54'd8192) >> 14;
    rnd14 = p[53] ? -signed'(r[26:0]) : signed'(r[26:0]);
  endfunction

  function automatic logic [23:0] sat24(input logic signed [39:0] v);
    logic signed [39:0] s;
    s = (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
    sat24 = s[23:0];
  endfunction

  assign sum_x = (state == S_EMP) ? 40'(ppx) + 40'(ox) : 40'(ppx) - 40'(ox);
  assign sum_y = (state == S_EMP) ? 40'(ppy) + 40'(oy) : 40'(ppy) - 40'(oy);

  // ---------------- next state ----------------
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (points.valid) begin
                  if (points_seen == 2'd0) state_next = points.data.final_point ? S_ERR : S_IDLE;
                  else state_next = S_DIFF;
                end
      S_ERR:    if (out_free) state_next = S_IDLE;
      S_DIFF:   state_next = S_NSHIFT;
      S_NSHIFT: begin
        if (m_max == '0) state_next = S_DIR;
        else if (m_max < MW'(1 << 24) || m_max >= MW'(1 << 25)) state_next = S_NSHIFT;
        else state_next = S_NSQX;
      end
      S_NSQX:   state_next = S_NSQY;
      S_NSQY:   state_next = S_NSQS;
      S_NSQS:   state_next = S_NSQRT;
      S_NSQRT:  if (dv_stat.done) state_next = S_NDIVX;
      S_NDIVX:  state_next = S_NWX;
      S_NWX:    if (dv_stat.done) state_next = S_NDIVY;
      S_NDIVY:  state_next = S_NWY;
      S_NWY:    if (dv_stat.done) state_next = nrm_mitre ? S_MIT : S_DIR;
      S_DIR:    state_next = S_PSUM;
      S_PSUM:   state_next = (s_abs < 18'(REVERSE_LIMIT)) ? S_OFFX : S_NSHIFT;
      S_MIT:    state_next = S_DOT1;
      S_DOT1:   state_next = S_DOT2;
      S_DOT2:   state_next = S_DOT3;
      S_DOT3:   state_next = (dot <= 0) ? S_OFFX : S_LDIV;
      S_LDIV:   if (dv_stat.done) state_next = S_OFFX;
      S_OFFX:   state_next = S_OFFY;
      S_OFFY:   state_next = S_OFFR;
      S_OFFR:   state_next = S_EMP;
      S_EMP:    if (out_free) state_next = S_EMM;
      S_EMM:    if (out_free) state_next = (!peol && fin) ? S_PSUM : S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // ---------------- unit controls ----------------
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    dv_ctrl = '0;
    opa     = '0;
    opb     = '0;
    case (state)
      S_NSQX: begin
        mul_a = signed'({2'b00, ax[24:0]});
        mul_b = signed'({2'b00, ax[24:0]});
      end
      S_NSQY: begin
        mul_a = signed'({2'b00, ay[24:0]});
        mul_b = signed'({2'b00, ay[24:0]});
      end
      S_NSQS: begin
        dv_ctrl.start     = 1'b1;
        dv_ctrl.sqrt_mode = 1'b1;
        opa               = acc[51:0] + prod[51:0];
      end
      S_NDIVX: begin
        dv_ctrl.start = 1'b1;
        opa           = 52'({ax[24:0], 14'b0}) + 52'(len[25:1]);
        opb           = 30'(len);
      end
      S_NDIVY: begin
        dv_ctrl.start = 1'b1;
        opa           = 52'({ay[24:0], 14'b0}) + 52'(len[25:1]);
        opb           = 30'(len);
      end
      S_DOT1: begin
        mul_a = 27'(nuy);
        mul_b = 27'(u1y);
      end
      S_DOT2: begin
        mul_a = 27'(nux);
        mul_b = 27'(u1x);
      end
      S_DOT3: begin
        dv_ctrl.start = !(dot <= 0);
        opa           = 52'({half_width, 28'b0}) + 52'(dot[29:1]);
        opb           = dot[29:0];
      end
      S_OFFX: begin
        mul_a = signed'({2'b00, l_reg});
        mul_b = 27'(mx);
      end
      S_OFFY: begin
        mul_a = signed'({2'b00, l_reg});
        mul_b = 27'(my);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      points_seen   <= 2'd0;
      point_counter <= '0;
      half_width    <= 16'd256;
      prev_x        <= '0;
      prev_y        <= '0;
      prev_dir_x    <= '0;
      prev_dir_y    <= '0;
      ov            <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) half_width <= cfg_wdata;
      if (ov_load) ov <= 1'b1;
      else if (verts.ready) ov <= 1'b0;
      case (state)
        S_IDLE: if (points.valid && points_seen == 2'd0 && !points.data.final_point) begin
          prev_x        <= pt_x;
          prev_y        <= pt_y;
          point_counter <= '0;
          points_seen   <= 2'd1;
        end
        S_ERR: if (out_free) begin
          point_counter <= '0;
        end
        S_EMM: if (out_free) begin
          if (peol) begin
            // line closed: back to an empty state
            prev_x        <= '0;
            prev_y        <= '0;
            prev_dir_x    <= '0;
            prev_dir_y    <= '0;
            points_seen   <= 2'd0;
            point_counter <= '0;
          end else begin
            point_counter <= cnt_inc;
            if (!fin) begin
              prev_x      <= in_x;
              prev_y      <= in_y;
              prev_dir_x  <= u1x;
              prev_dir_y  <= u1y;
              points_seen <= 2'd2;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      S_IDLE: begin
        in_x <= pt_x;
        in_y <= pt_y;
        fin  <= points.data.final_point;
      end
      S_ERR: if (out_free) begin
        od <= '{vert_x: '0, vert_y: '0, side: 1'b0, point_index: '0,
                single_point_error: 1'b1, end_of_line: 1'b1};
      end
      S_DIFF, S_PSUM: begin
        ax        <= nv_x[MW] ? MW'(-nv_x) : MW'(nv_x);
        ay        <= nv_y[MW] ? MW'(-nv_y) : MW'(nv_y);
        nsx       <= nv_x[MW];
        nsy       <= nv_y[MW];
        nrm_ok    <= 1'b1;
        nrm_mitre <= (state == S_PSUM);
        // reversed turn: mitre falls back to the segment normal
        mx        <= u1y;
        my        <= -u1x;
        l_reg     <= 25'(half_width);
      end
      S_NSHIFT: begin
        if (m_max == '0) begin
          nrm_ok <= 1'b0;
        end else if (m_max >= MW'(1 << 25)) begin
          ax <= ax >> 1;
          ay <= ay >> 1;
        end else if (m_max < MW'(1 << 24)) begin
          ax <= ax << 1;
          ay <= ay << 1;
        end
      end
      S_NSQY:  acc <= prod;
      S_NSQRT: if (dv_stat.done) len <= dv_q[25:0];
      S_NWX:   if (dv_stat.done) nux <= nq;
      S_NWY:   if (dv_stat.done) nuy <= nq;
      S_DIR: begin
        u1x  <= dsel_x;
        u1y  <= dsel_y;
        u0x  <= (points_seen == 2'd2) ? prev_dir_x : dsel_x;
        u0y  <= (points_seen == 2'd2) ? prev_dir_y : dsel_y;
        ppx  <= prev_x;
        ppy  <= prev_y;
        pidx <= point_counter;
        peol <= 1'b0;
      end
      S_MIT: begin
        mx <= nuy;
        my <= -nux;
      end
      S_DOT2: acc <= prod;
      S_DOT3: if (dot <= 0) l_reg <= 25'(L_CAP);
      S_LDIV: if (dv_stat.done) begin
        l_reg <= (dv_q > 48'(L_CAP)) ? 25'(L_CAP) : dv_q[24:0];
      end
      S_OFFY: ox <= rnd14(prod);
      S_OFFR: oy <= rnd14(prod);
      S_EMP: if (out_free) begin
        od <= '{vert_x: sat24(sum_x), vert_y: sat24(sum_y), side: 1'b0,
                point_index: idx_ext[11:0], single_point_error: 1'b0,
                end_of_line: 1'b0};
      end
      S_EMM: if (out_free) begin
        od <= '{vert_x: sat24(sum_x), vert_y: sat24(sum_y), side: 1'b1,
                point_index: idx_ext[11:0], single_point_error: 1'b0,
                end_of_line: peol};
        // final point of the line: queue its own pair
        if (!peol && fin) begin
          u0x  <= u1x;
          u0y  <= u1y;
          ppx  <= in_x;
          ppy  <= in_y;
          pidx <= cnt_inc;
          peol <= 1'b1;
        end
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

  assign points.ready = (state == S_IDLE);
  assign verts.valid  = ov;
  assign verts.data   = od;

  // ---------------- assertions ----------------
  a_unit_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !dv_stat.busy)
    else $error("div/sqrt unit busy while idle");

  a_seen_range: assert property (@(posedge clk) disable iff (rst)
    points_seen != 2'd3)
    else $error("points_seen out of range");

  a_err_eol: assert property (@(posedge clk) disable iff (rst)
    (ov && od.single_point_error) |-> od.end_of_line)
    else $error("error item without end_of_line");

  a_l_cap: assert property (@(posedge clk) disable iff (rst)
    (state == S_OFFX) |-> (l_reg <= 25'(L_CAP)))
    else $error("offset length above cap");

endmodule
`default_nettype wire

// ----- rtl/psk_divsqrt.sv -----
// ----------------------------------------------------------------------------
// psk_divsqrt: shared bit-serial divider / square root
// Restoring division (48 quotient bits) or integer sqrt (26 root bits),
// one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module psk_divsqrt (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire psk_pkg::dv_ctrl_t  ctrl,
  input  wire logic [51:0]        opa,
  input  wire logic [29:0]        opb,
  output psk_pkg::dv_stat_t       stat,
  output logic [47:0]             q
);
  import psk_pkg::*;

  logic        busy;
  logic        done;
  logic        sqm;
  logic [5:0]  cnt;
  logic [31:0] rem;
  logic [51:0] sh;
  logic [29:0] den;
  logic [33:0] t;
  logic [33:0] trial;
  logic [33:0] diff;
  logic        ge;

  always_comb begin
    t     = sqm ? {rem, sh[51:50]} : {1'b0, rem, sh[51]};
    trial = sqm ? {2'b00, q[29:0], 2'b01} : {4'b0000, den};
    ge    = (t >= trial);
    diff  = t - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 6'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      sqm <= ctrl.sqrt_mode;
      cnt <= ctrl.sqrt_mode ? 6'd25 : 6'd47;
      rem <= '0;
      q   <= '0;
      sh  <= ctrl.sqrt_mode ? opa : {opa[47:0], 4'b0000};
      den <= opb;
    end else if (busy) begin
      rem <= ge ? diff[31:0] : t[31:0];
      q   <= {q[46:0], ge};
      sh  <= sqm ? {sh[49:0], 2'b00} : {sh[50:0], 1'b0};
      cnt <= cnt - 6'd1;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: polyline_mitre_stroker
// Streams polylines of random and directed shape into the stroker. A local
// model of the mitre join predicts every vertex, and each output item is
// compared field by field in arrival order. Both sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
  import psk_pkg::*;

  localparam int  UNIT       = 16384;
  localparam int  CAP_L      = 16777216;
  localparam int  REV_LIMIT  = 64;
  localparam int  IDX_MASK   = 4095;
  localparam int  DRAIN_WAIT = 600;
  localparam longint CYCLE_LIMIT = 1500000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  psk_point_if points ();
  psk_vert_if  verts ();

  polyline_mitre_stroker DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .points(points.sink), .verts(verts.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Join model state: held point, last unit direction, count and width.
  // ---------------------------------------------------------------------------
  longint      held_x, held_y;
  int          last_ux, last_uy;
  int          held_count;        // 0 none, 1 first point, 2 with direction
  int          held_index;
  int          width_q8;
  vert_t       expected_verts[$];
  int          errors = 0;
  longint      cycles = 0;

  // Receiver controls: stall pattern and long hold-off
  bit          hold_off = 1'b0;
  int          stall_pct = 30;

  function automatic longint isqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Unit vector in Q1.14; returns 0 for a zero vector
  function automatic bit unit_vec(longint vx, longint vy, output int ux, output int uy);
    longint unsigned ax, ay, mg, len, qx, qy;
    ax = vx < 0 ? -vx : vx;
    ay = vy < 0 ? -vy : vy;
    mg = ax > ay ? ax : ay;
    ux = 0;
    uy = 0;
    if (mg == 0) return 1'b0;
    while (mg >= (64'd1 << 25)) begin
      ax >>= 1; ay >>= 1; mg >>= 1;
    end
    while (mg < (64'd1 << 24)) begin
      ax <<= 1; ay <<= 1; mg <<= 1;
    end
    len = isqrt(ax * ax + ay * ay);
    qx = (ax * UNIT + len / 2) / len;
    qy = (ay * UNIT + len / 2) / len;
    if (qx > UNIT) qx = UNIT;
    if (qy > UNIT) qy = UNIT;
    ux = vx < 0 ? -int'(qx) : int'(qx);
    uy = vy < 0 ? -int'(qy) : int'(qy);
    return 1'b1;
  endfunction

  function automatic longint clamp_coord(longint v);
    if (v > 64'sd8388607) return 8388607;
    if (v < -64'sd8388608) return -8388608;
    return v;
  endfunction

  function automatic longint offset_round(longint l, int c);
    longint p, q;
    p = l * c;
    q = ((p < 0 ? -p : p) + UNIT / 2) >>> 14;
    return p < 0 ? -q : q;
  endfunction

  // Queue the plus and minus vertices of one point
  task automatic queue_join(longint px, longint py, int u0x, int u0y, int u1x, int u1y,
                            int idx, bit eol);
    int     sx, sy, dx, dy, mx, my;
    longint l, ox, oy, dot;
    longint unsigned q;
    vert_t  v;
    sx = u0x + u1x;
    sy = u0y + u1y;
    if ((sx < 0 ? -sx : sx) + (sy < 0 ? -sy : sy) < REV_LIMIT) begin
      mx = u1y; my = -u1x;
      l = width_q8;
    end else begin
      void'(unit_vec(sx, sy, dx, dy));
      mx = dy; my = -dx;
      dot = longint'(dy) * u1y + longint'(dx) * u1x;
      if (dot <= 0) begin
        l = CAP_L;
      end else begin
        q = ((unsigned'(longint'(width_q8)) << 28) + dot / 2) / dot;
        l = q > CAP_L ? CAP_L : longint'(q);
      end
    end
    ox = offset_round(l, mx);
    oy = offset_round(l, my);
    v = '0;
    v.vert_x = 24'(clamp_coord(px + ox));
    v.vert_y = 24'(clamp_coord(py + oy));
    v.point_index = 12'(idx);
    expected_verts.push_back(v);
    v.vert_x = 24'(clamp_coord(px - ox));
    v.vert_y = 24'(clamp_coord(py - oy));
    v.side = 1'b1;
    v.end_of_line = eol;
    expected_verts.push_back(v);
  endtask

  task automatic predict_point(point_t p);
    longint px, py;
    int     u1x, u1y, u0x, u0y;
    vert_t  v;
    px = p.point_x;
    py = p.point_y;
    if (held_count == 0) begin
      held_index = 0;
      if (p.final_point) begin
        v = '0;
        v.single_point_error = 1'b1;
        v.end_of_line = 1'b1;
        expected_verts.push_back(v);
      end else begin
        held_x = px; held_y = py;
        held_count = 1;
      end
      return;
    end
    if (!unit_vec(px - held_x, py - held_y, u1x, u1y)) begin
      // zero-length segment keeps the old direction, or (1,0) at the start
      if (held_count == 2) begin
        u1x = last_ux; u1y = last_uy;
      end else begin
        u1x = UNIT; u1y = 0;
      end
    end
    if (held_count == 2) begin
      u0x = last_ux; u0y = last_uy;
    end else begin
      u0x = u1x; u0y = u1y;
    end
    queue_join(held_x, held_y, u0x, u0y, u1x, u1y, held_index, 1'b0);
    held_index = (held_index + 1) & IDX_MASK;
    if (p.final_point) begin
      queue_join(px, py, u1x, u1y, u1x, u1y, held_index, 1'b1);
      held_x = 0; held_y = 0; last_ux = 0; last_uy = 0;
      held_count = 0; held_index = 0;
    end else begin
      held_x = px; held_y = py;
      last_ux = u1x; last_uy = u1y;
      held_count = 2;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender: one item per call, bursts with random gaps. Valid stays up
  // between items of a burst and drops only for a gap or a drain.
  // ---------------------------------------------------------------------------
  int burst_left = 0;

  task automatic send_point(logic signed [23:0] x, logic signed [23:0] y, bit fin);
    point_t p;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        points.valid <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
    burst_left--;
    p.point_x = x;
    p.point_y = y;
    p.final_point = fin;
    points.data  <= p;
    points.valid <= 1'b1;
    do @(posedge clk); while (!points.ready);
    predict_point(p);
  endtask

  task automatic write_width(logic [15:0] w);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
    width_q8 = w;
  endtask

  // Wait until every queued vertex came back, then let the block settle
  task automatic drain();
    points.valid <= 1'b0;
    while (expected_verts.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern plus an optional long hold-off.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) verts.ready <= 1'b0;
    else verts.ready <= !hold_off && ($urandom_range(0, 99) >= stall_pct);
  end

  // Checker: compare each accepted vertex with the oldest expectation
  always @(posedge clk) begin
    vert_t e;
    vert_t a;
    if (!rst && verts.valid && verts.ready) begin
      a = verts.data;
      if (expected_verts.size() == 0) begin
        $display("%0t: unexpected vertex %h", $realtime, a);
        errors++;
      end else begin
        e = expected_verts.pop_front();
        if (a.vert_x !== e.vert_x)
          $display("%0t: vert_x exp %0d got %0d", $realtime, e.vert_x, a.vert_x);
        if (a.vert_y !== e.vert_y)
          $display("%0t: vert_y exp %0d got %0d", $realtime, e.vert_y, a.vert_y);
        if (a.side !== e.side)
          $display("%0t: side exp %0d got %0d", $realtime, e.side, a.side);
        if (a.point_index !== e.point_index)
          $display("%0t: point_index exp %0d got %0d", $realtime, e.point_index,
                   a.point_index);
        if (a.single_point_error !== e.single_point_error)
          $display("%0t: single_point_error exp %0d got %0d", $realtime,
                   e.single_point_error, a.single_point_error);
        if (a.end_of_line !== e.end_of_line)
          $display("%0t: end_of_line exp %0d got %0d", $realtime, e.end_of_line,
                   a.end_of_line);
        if (a !== e) errors++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_single_point();
    send_point(24'sd1000, -24'sd1000, 1'b1);
    send_point(24'sh7FFFFF, 24'sh800000, 1'b1);
  endtask

  // Straight line, right angle, reversal and zero-length segments
  task automatic test_shapes();
    send_point(24'sd0, 24'sd0, 1'b0);
    send_point(24'sd2560, 24'sd0, 1'b0);
    send_point(24'sd2560, 24'sd2560, 1'b0);      // right turn
    send_point(24'sd2560, 24'sd2560, 1'b0);      // zero-length keeps direction
    send_point(24'sd2560, 24'sd0, 1'b0);         // reversed turn
    send_point(-24'sd5000, 24'sd300, 1'b1);
    send_point(24'sd77, 24'sd77, 1'b0);
    send_point(24'sd77, 24'sd77, 1'b1);          // zero-length on first segment
  endtask

  // Coordinate extremes saturate the vertices
  task automatic test_extremes();
    send_point(24'sh7FFFFF, 24'sh7FFFFF, 1'b0);
    send_point(24'sh800000, 24'sh800000, 1'b0);
    send_point(24'sh7FFFFF, 24'sh800000, 1'b0);
    send_point(24'sh800000, 24'sh7FFFFF, 1'b1);
  endtask

  // Near-reversed acute join takes the reversed-turn fallback to the segment normal
  task automatic test_sharp_join();
    send_point(24'sd0, 24'sd0, 1'b0);
    send_point(24'sd100000, 24'sd0, 1'b0);
    send_point(24'sd0, 24'sd1, 1'b1);
  endtask

  // Random polylines, mostly short multi-point lines with some noise
  task automatic test_random(int n_items);
    int  left, len, k;
    logic signed [23:0] x, y;
    left = n_items;
    while (left > 0) begin
      len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 8);
      x = 24'($urandom);
      y = 24'($urandom);
      for (k = 0; k < len && left > 0; k++) begin
        if ($urandom_range(0, 5) == 0) begin
          x = 24'($urandom); y = 24'($urandom);     // far jump, full bit range
        end else if ($urandom_range(0, 9) != 0) begin
          x = x + $signed(24'($urandom_range(0, 8191)) - 24'sd4096);
          y = y + $signed(24'($urandom_range(0, 8191)) - 24'sd4096);
        end
        send_point(x, y, k == len - 1 || left == 1);
        left--;
      end
    end
  endtask

  // Receiver holds off while the sender keeps pushing, filling the block
  task automatic test_backpressure();
    int k;
    fork
      begin
        hold_off = 1'b1;
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
      for (k = 0; k < 8; k++)
        send_point(24'(k * 700), 24'(k * k * 90), k == 7);
    join
  endtask

  initial begin
    points.valid = 1'b0;
    points.data  = '0;
    held_x = 0; held_y = 0; last_ux = 0; last_uy = 0;
    held_count = 0; held_index = 0;
    width_q8 = 256;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_single_point();
    test_shapes();
    test_extremes();
    test_sharp_join();
    drain();
    write_width(16'd0);
    test_shapes();
    drain();
    write_width(16'hFFFF);
    test_sharp_join();
    test_extremes();
    drain();
    stall_pct = 60;
    write_width(16'd1200);
    test_backpressure();
    drain();
    stall_pct = 0;
    write_width(16'($urandom));
    test_random(30);
    drain();
    stall_pct = 35;
    write_width(16'd256);
    test_random(80);
    drain();

    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
